### design/pes_pkg.sv
// PES parser package: phase codes, header sub-state codes, class codes.
// No dependencies.
package pes_pkg;
    localparam int LookaheadBytes = 4;

    localparam logic [2:0] PH_SEEK0   = 3'd0;
    localparam logic [2:0] PH_ONEZERO = 3'd1;
    localparam logic [2:0] PH_ZEROS   = 3'd2;
    localparam logic [2:0] PH_ID      = 3'd3;
    localparam logic [2:0] PH_LENHI   = 3'd4;
    localparam logic [2:0] PH_LENLO   = 3'd5;
    localparam logic [2:0] PH_HEADER  = 3'd6;
    localparam logic [2:0] PH_BODY    = 3'd7;

    localparam logic [2:0] HS_FIRST   = 3'd0;
    localparam logic [2:0] HS_M2FLAGS = 3'd1;
    localparam logic [2:0] HS_M2HDL   = 3'd2;
    localparam logic [2:0] HS_M2REST  = 3'd3;
    localparam logic [2:0] HS_M1STUFF = 3'd4;
    localparam logic [2:0] HS_M1STDB  = 3'd5;
    localparam logic [2:0] HS_M1CODE  = 3'd6;
    localparam logic [2:0] HS_M1TS    = 3'd7;

    localparam logic [2:0] CL_UNKNOWN = 3'd0;
    localparam logic [2:0] CL_AC3     = 3'd1;
    localparam logic [2:0] CL_PRIVATE = 3'd2;
    localparam logic [2:0] CL_AUDIO   = 3'd3;
    localparam logic [2:0] CL_VIDEO   = 3'd4;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        first_of_packet;
        logic        last_of_packet;
        logic [7:0]  stream_number;
        logic [2:0]  stream_class;
        logic [4:0]  sub_stream;
        logic [32:0] pts_value;
        logic        pts_present;
        logic [32:0] dts_value;
        logic        dts_present;
        logic [15:0] payload_count;
    } t_result;

    // Fold one timestamp byte into an accumulator; k is the byte index 0..4.
    function automatic logic [32:0] ts_fold(input logic [32:0] acc, input logic [2:0] k,
                                            input logic [7:0] b);
        logic [32:0] r;
        case (k)
            3'd0: r = {30'd0, b[3:1]};
            3'd1, 3'd3: r = {acc[24:0], b};
            default: r = {acc[25:0], b[7:1]};
        endcase
        return r;
    endfunction
endpackage

### design/pes_parse.sv
// PES parser state machine: one stream byte per request, at most one result.
// Depends on pes_pkg.
module pes_parse #(
    parameter int LOOKAHEAD_BYTES = pes_pkg::LookaheadBytes
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output logic             o_emit,
    output pes_pkg::t_result o_res
);
    localparam int CW = $clog2(LOOKAHEAD_BYTES + 1);

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_stream, n_stream;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_hsize, n_hsize;
    logic [32:0] r_pts, n_pts, r_dts, n_dts;
    logic        r_fpts, n_fpts, r_fdts, n_fdts;
    logic        r_started, n_started;
    logic [7:0]  r_hold [LOOKAHEAD_BYTES];
    logic [7:0]  n_hold [LOOKAHEAD_BYTES];
    logic [CW-1:0] r_hcnt, n_hcnt;
    logic [2:0]  r_hsub, n_hsub;
    logic [3:0]  r_tsi, n_tsi;
    logic [3:0]  r_tsn, n_tsn;
    logic [2:0]  r_cls, n_cls;
    logic [4:0]  r_sub, n_sub;
    logic [1:0]  r_skip, n_skip;
    logic [15:0] r_pcnt, n_pcnt;
    logic        r_pend, n_pend;

    logic        emit;
    logic [7:0]  e_byte;
    logic        e_has, e_last;
    logic [2:0]  e_cls;
    logic [4:0]  e_sub;
    logic [15:0] e_pcnt;
    logic        done, last, start_hit;
    logic [7:0]  bb;
    logic        blast, b_do;
    logic [3:0]  tsi_w;
    logic [2:0]  ts_k;
    logic [7:0]  tb;
    logic        ts_do;
    logic [15:0] pos1;
    logic [CW-1:0] hc;
    logic        new_pkt;
    logic [7:0]  new_id;

    assign pos1 = r_pos + 16'd1;

    always_comb begin
        n_phase = r_phase; n_stream = r_stream; n_len = r_len; n_pos = r_pos;
        n_hsize = r_hsize; n_pts = r_pts; n_dts = r_dts;
        n_fpts = r_fpts; n_fdts = r_fdts; n_started = r_started; n_hold = r_hold;
        n_hcnt = r_hcnt; n_hsub = r_hsub; n_tsi = r_tsi; n_tsn = r_tsn;
        n_cls = r_cls; n_sub = r_sub; n_skip = r_skip; n_pcnt = r_pcnt;
        n_pend = r_pend;
        emit = 1'b0; e_byte = 8'd0; e_has = 1'b0; e_last = 1'b0;
        done = 1'b0; last = 1'b0; start_hit = 1'b0; bb = i_byte; blast = 1'b0;
        b_do = 1'b0; ts_do = 1'b0; tsi_w = r_tsi; tb = i_byte; ts_k = 3'd0;
        new_pkt = 1'b0; new_id = i_byte; hc = r_hcnt;

        case (r_phase)
            pes_pkg::PH_SEEK0: if (i_byte == 8'd0) n_phase = pes_pkg::PH_ONEZERO;
            pes_pkg::PH_ONEZERO:
                n_phase = (i_byte == 8'd0) ? pes_pkg::PH_ZEROS : pes_pkg::PH_SEEK0;
            pes_pkg::PH_ZEROS: begin
                if (i_byte == 8'd1) n_phase = pes_pkg::PH_ID;
                else if (i_byte != 8'd0) n_phase = pes_pkg::PH_SEEK0;
            end
            pes_pkg::PH_ID: begin
                if (i_byte > 8'hbb) new_pkt = 1'b1;
                else n_phase = (i_byte == 8'd0) ? pes_pkg::PH_ONEZERO : pes_pkg::PH_SEEK0;
            end
            pes_pkg::PH_LENHI: begin
                n_len = {i_byte, 8'd0};
                n_phase = pes_pkg::PH_LENLO;
            end
            pes_pkg::PH_LENLO: begin
                n_len = {r_len[15:8], i_byte};
                n_pos = 16'd0;
                n_phase = pes_pkg::PH_HEADER;
            end
            pes_pkg::PH_HEADER: begin
                // header sub-state step
                case (r_hsub)
                    pes_pkg::HS_FIRST, pes_pkg::HS_M1STUFF, pes_pkg::HS_M1CODE: begin
                        if (r_hsub == pes_pkg::HS_FIRST && i_byte[7:6] == 2'd2) begin
                            n_hsub = pes_pkg::HS_M2FLAGS;
                        end else if (r_hsub != pes_pkg::HS_M1CODE && i_byte == 8'hff) begin
                            n_hsub = pes_pkg::HS_M1STUFF;
                        end else if (r_hsub != pes_pkg::HS_M1CODE && i_byte[7:6] == 2'd1) begin
                            n_hsub = pes_pkg::HS_M1STDB;
                        end else if (i_byte[7:4] == 4'd2 || i_byte[7:4] == 4'd3) begin
                            n_tsn = (i_byte[7:4] == 4'd2) ? 4'd5 : 4'd10;
                            tsi_w = 4'd0;
                            ts_do = 1'b1;
                            n_hsub = pes_pkg::HS_M1TS;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    pes_pkg::HS_M2FLAGS: begin
                        n_tsn = (i_byte[7:6] == 2'd2) ? 4'd5 :
                                (i_byte[7:6] == 2'd3) ? 4'd10 : 4'd0;
                        n_hsub = pes_pkg::HS_M2HDL;
                    end
                    pes_pkg::HS_M2HDL: begin
                        n_hsize = i_byte;
                        n_tsi = 4'd0;
                        n_hsub = pes_pkg::HS_M2REST;
                        done = (i_byte == 8'd0);
                    end
                    pes_pkg::HS_M2REST: begin
                        if (r_tsi < r_tsn) ts_do = 1'b1;
                        done = (r_pos - 16'd2) >= {8'd0, r_hsize};
                    end
                    pes_pkg::HS_M1STDB: n_hsub = pes_pkg::HS_M1CODE;
                    default: begin
                        ts_do = 1'b1;
                        done = (r_tsi + 4'd1) >= r_tsn;
                    end
                endcase
                last = (r_len != 16'd0) && (pos1 >= r_len);
                if (done) begin
                    if (r_len != 16'd0 && !last && r_cls != pes_pkg::CL_UNKNOWN)
                        n_pcnt = r_len - pos1;
                    else
                        n_pcnt = 16'd0;
                end
                if (last) begin
                    if (r_pend) begin
                        n_pend = 1'b0;
                        n_cls = pes_pkg::CL_PRIVATE;
                    end
                    emit = 1'b1; e_last = 1'b1;
                    n_phase = pes_pkg::PH_SEEK0;
                end else begin
                    n_pos = pos1;
                    if (done) begin
                        n_phase = pes_pkg::PH_BODY;
                        n_hcnt = '0;
                    end
                end
            end
            default: begin
                if (r_len != 16'd0) begin
                    blast = pos1 >= r_len;
                    n_pos = pos1;
                    b_do = 1'b1;
                    if (blast) n_phase = pes_pkg::PH_SEEK0;
                end else begin
                    start_hit = 1'b0;
                    for (int k = 3; k <= LOOKAHEAD_BYTES; k++) begin
                        if (hc == CW'(k) && r_hold[k-3] == 8'd0 && r_hold[k-2] == 8'd0 &&
                            r_hold[k-1] == 8'd1 && i_byte > 8'hbb)
                            start_hit = 1'b1;
                    end
                    if (start_hit) begin
                        if (hc > CW'(3)) begin
                            bb = r_hold[0]; blast = 1'b1; b_do = 1'b1;
                        end else begin
                            if (r_pend) begin
                                n_pend = 1'b0;
                                n_cls = pes_pkg::CL_PRIVATE;
                            end
                            emit = 1'b1; e_last = 1'b1;
                        end
                        new_pkt = 1'b1;
                    end else if (hc < CW'(LOOKAHEAD_BYTES)) begin
                        for (int k = 0; k < LOOKAHEAD_BYTES; k++)
                            if (hc == CW'(k)) n_hold[k] = i_byte;
                        n_hcnt = hc + CW'(1);
                    end else begin
                        bb = r_hold[0]; b_do = 1'b1;
                        for (int k = 0; k < LOOKAHEAD_BYTES - 1; k++)
                            n_hold[k] = r_hold[k+1];
                        n_hold[LOOKAHEAD_BYTES-1] = i_byte;
                    end
                end
            end
        endcase

        // timestamp byte fold
        if (ts_do) begin
            ts_k = (tsi_w >= 4'd5) ? 3'(tsi_w - 4'd5) : tsi_w[2:0];
            if (tsi_w < 4'd5) begin
                n_pts = pes_pkg::ts_fold(r_pts, ts_k, tb);
                if (ts_k == 3'd4) n_fpts = 1'b1;
            end else if (tsi_w < 4'd10) begin
                n_dts = pes_pkg::ts_fold(r_dts, ts_k, tb);
                if (ts_k == 3'd4) n_fdts = 1'b1;
            end
            n_tsi = tsi_w + 4'd1;
        end

        // payload byte handling
        if (b_do) begin
            if (r_pend) begin
                n_pend = 1'b0;
                if (bb >= 8'h80 && bb <= 8'h8f) begin
                    n_cls = pes_pkg::CL_AC3;
                    n_sub = {1'b0, bb[3:0]};
                    n_skip = 2'd3;
                    n_pcnt = (r_pcnt >= 16'd4) ? r_pcnt - 16'd4 : 16'd0;
                end else begin
                    n_cls = pes_pkg::CL_PRIVATE;
                    n_sub = 5'd0;
                    n_pcnt = 16'd0;
                end
                if (blast) begin emit = 1'b1; e_last = 1'b1; end
            end else if (r_skip != 2'd0) begin
                n_skip = r_skip - 2'd1;
                if (blast) begin emit = 1'b1; e_last = 1'b1; end
            end else if (r_cls == pes_pkg::CL_AC3 || r_cls == pes_pkg::CL_AUDIO ||
                         r_cls == pes_pkg::CL_VIDEO) begin
                emit = 1'b1; e_has = 1'b1; e_byte = bb; e_last = blast;
            end else if (blast) begin
                emit = 1'b1; e_last = 1'b1;
            end
        end

        if (emit) n_started = 1'b1;

        // hold the closing packet's fields before a new packet overwrites them
        e_cls = n_cls; e_sub = n_sub; e_pcnt = n_pcnt;

        // open a new packet
        if (new_pkt) begin
            n_stream = new_id; n_phase = pes_pkg::PH_LENHI;
            n_len = 16'd0; n_pos = 16'd0; n_hsize = 8'd0; n_pts = '0; n_dts = '0;
            n_fpts = 1'b0; n_fdts = 1'b0; n_started = 1'b0;
            n_hcnt = '0; n_hsub = pes_pkg::HS_FIRST; n_tsi = 4'd0; n_tsn = 4'd0;
            n_skip = 2'd0; n_pcnt = 16'd0; n_pend = 1'b0; n_sub = 5'd0;
            if (new_id == 8'hbd) begin
                n_cls = pes_pkg::CL_PRIVATE; n_pend = 1'b1;
            end else if (new_id >= 8'hc0 && new_id <= 8'hdf) begin
                n_cls = pes_pkg::CL_AUDIO; n_sub = new_id[4:0];
            end else if (new_id >= 8'he0 && new_id <= 8'hef) begin
                n_cls = pes_pkg::CL_VIDEO; n_sub = {1'b0, new_id[3:0]};
            end else begin
                n_cls = pes_pkg::CL_UNKNOWN;
            end
        end
    end

    // result fields from the pre-update state; class, sub-stream, count and header-phase timestamps use updated values
    always_comb begin
        o_emit = emit;
        o_res.payload_byte = e_byte;
        o_res.has_byte = e_has;
        o_res.first_of_packet = ~r_started;
        o_res.last_of_packet = e_last;
        o_res.stream_number = r_stream;
        o_res.stream_class = (b_do || last) ? e_cls : r_cls;
        o_res.sub_stream = (b_do || last) ? e_sub : r_sub;
        o_res.pts_value = r_fpts ? r_pts : 33'd0;
        o_res.pts_present = r_fpts;
        o_res.dts_value = r_fdts ? r_dts : 33'd0;
        o_res.dts_present = r_fdts;
        o_res.payload_count = (b_do || last) ? e_pcnt : r_pcnt;
        if (r_phase == pes_pkg::PH_HEADER) begin
            o_res.pts_value = n_fpts ? n_pts : 33'd0;
            o_res.pts_present = n_fpts;
            o_res.dts_value = n_fdts ? n_dts : 33'd0;
            o_res.dts_present = n_fdts;
        end
    end

    // advance state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pes_pkg::PH_SEEK0; r_stream <= 8'd0; r_len <= 16'd0;
            r_pos <= 16'd0; r_hsize <= 8'd0; r_pts <= '0; r_dts <= '0;
            r_fpts <= 1'b0; r_fdts <= 1'b0; r_started <= 1'b0;
            for (int k = 0; k < LOOKAHEAD_BYTES; k++) r_hold[k] <= 8'd0;
            r_hcnt <= '0; r_hsub <= pes_pkg::HS_FIRST; r_tsi <= 4'd0; r_tsn <= 4'd0;
            r_cls <= pes_pkg::CL_UNKNOWN; r_sub <= 5'd0; r_skip <= 2'd0;
            r_pcnt <= 16'd0; r_pend <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase; r_stream <= n_stream; r_len <= n_len; r_pos <= n_pos;
            r_hsize <= n_hsize; r_pts <= n_pts; r_dts <= n_dts;
            r_fpts <= n_fpts; r_fdts <= n_fdts; r_started <= n_started; r_hold <= n_hold;
            r_hcnt <= n_hcnt; r_hsub <= n_hsub; r_tsi <= n_tsi; r_tsn <= n_tsn;
            r_cls <= n_cls; r_sub <= n_sub; r_skip <= n_skip; r_pcnt <= n_pcnt;
            r_pend <= n_pend;
        end
    end
endmodule

### design/pes_packet_parser_core.sv
// PES packet parser top level: input register, parse stage, output skid queue.
// A byte is registered on acceptance, parsed, and its result written into the output queue.
// The single-pass parse stage takes one byte per cycle while o_stall is low; o_stall rises as the queue fills.
// Reset: synchronous active-low i_rst_n clears the search state and empties queues.
// Depends on pes_pkg and pes_parse.
module pes_packet_parser_core #(
    parameter int LOOKAHEAD_BYTES = pes_pkg::LookaheadBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_has_byte,
    output logic        o_first_of_packet,
    output logic        o_last_of_packet,
    output logic [7:0]  o_stream_number,
    output logic [2:0]  o_stream_class,
    output logic [4:0]  o_sub_stream,
    output logic [32:0] o_pts_value,
    output logic        o_pts_present,
    output logic [32:0] o_dts_value,
    output logic        o_dts_present,
    output logic [15:0] o_payload_count
);
    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             take, emit;
    pes_pkg::t_result res;
    // three-entry output queue
    pes_pkg::t_result r_q [3];
    logic [1:0]       r_cnt;
    logic [1:0]       wr_idx;
    logic             out_pop, push;

    // accept while the queue can absorb the in-flight result and one more
    assign o_stall = (r_cnt == 2'd3) || (r_cnt == 2'd2 && r_in_vld);
    assign take    = r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_valid && !o_stall;
        end
        r_in_byte <= i_data_byte;
    end

    pes_parse #(.LOOKAHEAD_BYTES(LOOKAHEAD_BYTES)) u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_byte (r_in_byte),
        .o_emit (emit),
        .o_res  (res)
    );

    assign push    = take && emit;
    assign out_pop = o_valid && !i_stall;
    assign wr_idx  = r_cnt - {1'b0, out_pop};

    // queue update: shift on pop, write the new result behind the survivors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, out_pop};
        end
        for (int k = 0; k < 2; k++) begin
            if (push && wr_idx == 2'(k)) r_q[k] <= res;
            else if (out_pop) r_q[k] <= r_q[k+1];
        end
        if (push && wr_idx == 2'd2) r_q[2] <= res;
    end

    assign o_valid           = r_cnt != 2'd0;
    assign o_payload_byte    = r_q[0].payload_byte;
    assign o_has_byte        = r_q[0].has_byte;
    assign o_first_of_packet = r_q[0].first_of_packet;
    assign o_last_of_packet  = r_q[0].last_of_packet;
    assign o_stream_number   = r_q[0].stream_number;
    assign o_stream_class    = r_q[0].stream_class;
    assign o_sub_stream      = r_q[0].sub_stream;
    assign o_pts_value       = r_q[0].pts_value;
    assign o_pts_present     = r_q[0].pts_present;
    assign o_dts_value       = r_q[0].dts_value;
    assign o_dts_present     = r_q[0].dts_present;
    assign o_payload_count   = r_q[0].payload_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cnt == 2'd3 && push && !out_pop)) else $error("result queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} + {2'b0, r_in_vld}) <= 3'd3) else $error("queue over capacity");
    a_byte_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_last_of_packet) else $error("empty result not last");
`endif
endmodule

### bench/tb_pes_packet_parser_core.sv
// Self-checking bench for pes_packet_parser_core: directed and random PES program streams
// are predicted byte by byte and compared with every result. Depends on pes_pkg.
module tb_pes_packet_parser_core;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_payload_byte;
    logic        o_has_byte;
    logic        o_first_of_packet;
    logic        o_last_of_packet;
    logic [7:0]  o_stream_number;
    logic [2:0]  o_stream_class;
    logic [4:0]  o_sub_stream;
    logic [32:0] o_pts_value;
    logic        o_pts_present;
    logic [32:0] o_dts_value;
    logic        o_dts_present;
    logic [15:0] o_payload_count;

    pes_packet_parser_core i_dut (.*);

    // Header flag bits of the predictor
    localparam logic [5:0] FlMpeg2   = 6'd1;
    localparam logic [5:0] FlPts     = 6'd8;
    localparam logic [5:0] FlDts     = 6'd16;
    localparam logic [5:0] FlStarted = 6'd32;

    // Predictor state
    logic [2:0]  sync_ph;
    logic [7:0]  cur_id;
    logic [15:0] pkt_len;
    logic [15:0] pos;
    logic [7:0]  hdr_len;
    logic [32:0] pts_acc;
    logic [32:0] dts_acc;
    logic [5:0]  flags;
    logic [7:0]  hold [4];
    int          hold_cnt;
    logic [2:0]  hsub;
    int          ts_idx;
    int          ts_need;
    logic [2:0]  cls;
    logic [4:0]  sub;
    int          skip_cnt;
    logic [15:0] pay_cnt;
    bit          cls_pending;

    pes_pkg::t_result result_q [$];
    logic [7:0]  byte_q [$];
    int          errors;
    int          mismatches;
    int          cycles;
    bit          stim_done;

    task automatic emit(input logic [7:0] b, input bit has, input bit last);
        pes_pkg::t_result r;
        r.payload_byte    = has ? b : 8'd0;
        r.has_byte        = has;
        r.first_of_packet = !flags[5];
        r.last_of_packet  = last;
        r.stream_number   = cur_id;
        r.stream_class    = cls;
        r.sub_stream      = sub;
        r.pts_value       = flags[3] ? pts_acc : 33'd0;
        r.pts_present     = flags[3];
        r.dts_value       = flags[4] ? dts_acc : 33'd0;
        r.dts_present     = flags[4];
        r.payload_count   = pay_cnt;
        flags |= FlStarted;
        result_q.push_back(r);
    endtask

    task automatic open_packet(input logic [7:0] id);
        cur_id = id;
        sync_ph = pes_pkg::PH_LENHI;
        pkt_len = 0; pos = 0; hdr_len = 0; pts_acc = 0; dts_acc = 0; flags = 0;
        hold_cnt = 0; hsub = pes_pkg::HS_FIRST; ts_idx = 0; ts_need = 0; skip_cnt = 0;
        pay_cnt = 0; cls_pending = 0; sub = 0;
        if (id == 8'hbd) begin
            cls = pes_pkg::CL_PRIVATE; cls_pending = 1;
        end else if (id >= 8'hc0 && id <= 8'hdf) begin
            cls = pes_pkg::CL_AUDIO; sub = id[4:0];
        end else if (id >= 8'he0 && id <= 8'hef) begin
            cls = pes_pkg::CL_VIDEO; sub = {1'b0, id[3:0]};
        end else begin
            cls = pes_pkg::CL_UNKNOWN;
        end
    endtask

    // Return the predictor to its after-reset state
    task automatic reset_predictor();
        open_packet(8'd0);
        sync_ph = pes_pkg::PH_SEEK0;
        cls = pes_pkg::CL_UNKNOWN;
        sub = 0;
        for (int k = 0; k < 4; k++) hold[k] = 0;
    endtask

    function automatic logic [32:0] fold_ts(input logic [32:0] acc, input int k,
                                            input logic [7:0] b);
        case (k)
            0: return {30'd0, b[3:1]};
            1, 3: return {acc[24:0], b};
            default: return {acc[25:0], b[7:1]};
        endcase
    endfunction

    function automatic void take_ts(input logic [7:0] b);
        int k;
        k = ts_idx % 5;
        if (ts_idx < 5) begin
            pts_acc = fold_ts(pts_acc, k, b);
            if (k == 4) flags |= FlPts;
        end else if (ts_idx < 10) begin
            dts_acc = fold_ts(dts_acc, k, b);
            if (k == 4) flags |= FlDts;
        end
        ts_idx++;
    endfunction

    function automatic bit mpeg1_code(input logic [7:0] b);
        if (b[7:4] == 4'd2) ts_need = 5;
        else if (b[7:4] == 4'd3) ts_need = 10;
        else return 1;
        ts_idx = 0;
        take_ts(b);
        hsub = pes_pkg::HS_M1TS;
        return 0;
    endfunction

    function automatic bit mpeg1_stuff(input logic [7:0] b);
        if (b == 8'hff) begin
            hsub = pes_pkg::HS_M1STUFF; return 0;
        end
        if (b[7:6] == 2'd1) begin
            hsub = pes_pkg::HS_M1STDB; return 0;
        end
        return mpeg1_code(b);
    endfunction

    // Returns 1 when the byte completes the header
    function automatic bit parse_header(input logic [7:0] b);
        case (hsub)
            pes_pkg::HS_FIRST: begin
                if (b[7:6] == 2'd2) begin
                    flags |= FlMpeg2; hsub = pes_pkg::HS_M2FLAGS; return 0;
                end
                return mpeg1_stuff(b);
            end
            pes_pkg::HS_M2FLAGS: begin
                ts_need = (b[7:6] == 2'd2) ? 5 : (b[7:6] == 2'd3) ? 10 : 0;
                hsub = pes_pkg::HS_M2HDL;
                return 0;
            end
            pes_pkg::HS_M2HDL: begin
                hdr_len = b; ts_idx = 0; hsub = pes_pkg::HS_M2REST;
                return b == 0;
            end
            pes_pkg::HS_M2REST: begin
                if (ts_idx < ts_need) take_ts(b);
                return 32'(pos) - 2 >= 32'(hdr_len);
            end
            pes_pkg::HS_M1STUFF: return mpeg1_stuff(b);
            pes_pkg::HS_M1STDB: begin
                hsub = pes_pkg::HS_M1CODE; return 0;
            end
            pes_pkg::HS_M1CODE: return mpeg1_code(b);
            default: begin
                take_ts(b);
                return ts_idx >= ts_need;
            end
        endcase
    endfunction

    task automatic body(input logic [7:0] b, input bit last);
        if (cls_pending) begin
            cls_pending = 0;
            if (b >= 8'h80 && b <= 8'h8f) begin
                cls = pes_pkg::CL_AC3; sub = {1'b0, b[3:0]}; skip_cnt = 3;
                pay_cnt = pay_cnt >= 4 ? pay_cnt - 16'd4 : 16'd0;
            end else begin
                cls = pes_pkg::CL_PRIVATE; sub = 0; pay_cnt = 0;
            end
        end else if (skip_cnt > 0) begin
            skip_cnt--;
        end else if (cls == pes_pkg::CL_AC3 || cls == pes_pkg::CL_AUDIO ||
                     cls == pes_pkg::CL_VIDEO) begin
            emit(b, 1, last);
            return;
        end
        if (last) emit(8'd0, 0, 1);
    endtask

    // Advance the predictor by one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        bit done, last;
        logic [7:0] old;
        case (sync_ph)
            pes_pkg::PH_SEEK0: if (b == 0) sync_ph = pes_pkg::PH_ONEZERO;
            pes_pkg::PH_ONEZERO: sync_ph = (b == 0) ? pes_pkg::PH_ZEROS : pes_pkg::PH_SEEK0;
            pes_pkg::PH_ZEROS: begin
                if (b == 1) sync_ph = pes_pkg::PH_ID;
                else if (b != 0) sync_ph = pes_pkg::PH_SEEK0;
            end
            pes_pkg::PH_ID: begin
                if (b > 8'hbb) open_packet(b);
                else sync_ph = (b == 0) ? pes_pkg::PH_ONEZERO : pes_pkg::PH_SEEK0;
            end
            pes_pkg::PH_LENHI: begin
                pkt_len = {b, 8'd0}; sync_ph = pes_pkg::PH_LENLO;
            end
            pes_pkg::PH_LENLO: begin
                pkt_len[7:0] = b; pos = 0; sync_ph = pes_pkg::PH_HEADER;
            end
            pes_pkg::PH_HEADER: begin
                done = parse_header(b);
                last = pkt_len != 0 && 32'(pos) + 1 >= 32'(pkt_len);
                if (done) begin
                    if (pkt_len != 0 && !last && cls != pes_pkg::CL_UNKNOWN)
                        pay_cnt = pkt_len - (pos + 16'd1);
                    else
                        pay_cnt = 0;
                end
                if (last) begin
                    if (cls_pending) begin
                        cls_pending = 0; cls = pes_pkg::CL_PRIVATE;
                    end
                    emit(8'd0, 0, 1);
                    sync_ph = pes_pkg::PH_SEEK0;
                end else begin
                    pos++;
                    if (done) begin
                        sync_ph = pes_pkg::PH_BODY; hold_cnt = 0;
                    end
                end
            end
            default: begin
                if (pkt_len != 0) begin
                    last = 32'(pos) + 1 >= 32'(pkt_len);
                    pos++;
                    body(b, last);
                    if (last) sync_ph = pes_pkg::PH_SEEK0;
                end else if (hold_cnt >= 3 && hold[hold_cnt-3] == 0 &&
                             hold[hold_cnt-2] == 0 && hold[hold_cnt-1] == 1 &&
                             b > 8'hbb) begin
                    // Start code found: close this packet, open the next
                    if (hold_cnt > 3) begin
                        body(hold[0], 1);
                    end else begin
                        if (cls_pending) begin
                            cls_pending = 0; cls = pes_pkg::CL_PRIVATE;
                        end
                        emit(8'd0, 0, 1);
                    end
                    open_packet(b);
                end else if (hold_cnt < 4) begin
                    hold[hold_cnt] = b;
                    hold_cnt++;
                end else begin
                    old = hold[0];
                    hold[0] = hold[1]; hold[1] = hold[2]; hold[2] = hold[3];
                    hold[3] = b;
                    body(old, 0);
                end
            end
        endcase
    endtask

    // Stimulus generation helpers
    task automatic push_ts(input logic [3:0] tag, input logic [32:0] v);
        byte_q.push_back({tag, v[32:30], 1'b1});
        byte_q.push_back(v[29:22]);
        byte_q.push_back({v[21:15], 1'b1});
        byte_q.push_back(v[14:7]);
        byte_q.push_back({v[6:0], 1'b1});
    endtask

    function automatic logic [32:0] rand_ts();
        return {1'($urandom_range(0, 1)), $urandom()};
    endfunction

    function automatic logic [7:0] rand_id();
        case ($urandom_range(0, 4))
            0: return 8'hbd;
            1: return 8'(8'hc0 + $urandom_range(0, 31));
            2: return 8'(8'he0 + $urandom_range(0, 15));
            3: return 8'(8'hbc + $urandom_range(0, 67));
            default: return 8'(8'hbc + $urandom_range(0, 3));
        endcase
    endfunction

    // Build one packet; len_mode 0 known length, 1 unspecified, 2 truncated
    task automatic push_packet(input logic [7:0] id, input bit mpeg2, input int ts_mode,
                               input int pay, input int len_mode);
        logic [7:0] hdr [$];
        int extra, len, hsz, i;
        extra = 0;
        if (mpeg2) begin
            extra = $urandom_range(0, 2);
            hdr.push_back(8'h80 | 8'($urandom_range(0, 63)));
            hdr.push_back(ts_mode == 2 ? 8'hc0 : ts_mode == 1 ? 8'h80 : 8'h00);
            hdr.push_back(8'(ts_mode * 5 + extra));
        end else begin
            repeat ($urandom_range(0, 3)) hdr.push_back(8'hff);
            if ($urandom_range(0, 1)) begin
                hdr.push_back(8'h40 | 8'($urandom_range(0, 63)));
                hdr.push_back(8'($urandom()));
            end
            if (ts_mode == 0) hdr.push_back(8'h0f);
        end
        // header bytes: fixed part, timestamps, stuffing
        hsz = hdr.size() + ts_mode * 5 + extra;
        byte_q.push_back(8'h00); byte_q.push_back(8'h00);
        if ($urandom_range(0, 3) == 0) byte_q.push_back(8'h00);
        byte_q.push_back(8'h01); byte_q.push_back(id);
        len = hsz + pay;
        if (len_mode == 2) len = $urandom_range(1, hsz + 1);
        if (len_mode == 1) len = 0;
        byte_q.push_back(8'(len >> 8)); byte_q.push_back(8'(len));
        foreach (hdr[j]) byte_q.push_back(hdr[j]);
        if (ts_mode >= 1)
            push_ts(ts_mode == 2 ? 4'd3 : 4'd2, rand_ts());
        if (ts_mode == 2) push_ts(4'd1, rand_ts());
        if (mpeg2) repeat (extra) byte_q.push_back(8'hff);
        if (id == 8'hbd && pay > 0 && $urandom_range(0, 2) != 0) begin
            byte_q.push_back(8'(8'h80 + $urandom_range(0, 15)));
            pay--;
        end
        for (i = 0; i < pay; i++) byte_q.push_back(8'($urandom()));
    endtask

    // Clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Reset and stimulus
    initial begin
        int k;
        i_rst_n = 0;
        // Directed: extremes, both header forms, timestamp kinds, short headers
        byte_q.push_back(8'hff); byte_q.push_back(8'h00); byte_q.push_back(8'h00);
        byte_q.push_back(8'h01); byte_q.push_back(8'hbb);
        push_packet(8'he0, 1, 2, 2, 0);
        push_packet(8'hdf, 0, 2, 1, 0);
        push_packet(8'hbd, 1, 1, 6, 0);
        push_packet(8'hff, 0, 1, 3, 0);
        push_packet(8'hef, 1, 2, 0, 0);
        push_packet(8'hc0, 1, 1, 0, 2);
        push_packet(8'hbd, 0, 0, 2, 2);
        push_packet(8'hc5, 1, 0, 4, 1);
        push_packet(8'hbd, 1, 0, 5, 1);
        // Random: mostly well-formed packets, some noise
        while (byte_q.size() < 1550) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom()));
            end else begin
                k = $urandom_range(0, 9);
                push_packet(rand_id(), 1'($urandom_range(0, 1)), $urandom_range(0, 2),
                            $urandom_range(0, 12), k < 6 ? 0 : k < 8 ? 1 : 2);
            end
        end
        // Close a trailing unspecified packet
        push_packet(8'he1, 1, 0, 1, 0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // Driver: bursts and gaps
    int gap_left, burst_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0; i_data_byte <= 0;
            gap_left <= 0; burst_left <= 0;
            reset_predictor();
        end else begin
            if (i_valid && !o_stall) predict_byte(i_data_byte);
            if (!i_valid || !o_stall) begin
                if (byte_q.size() == 0) begin
                    i_valid <= 0; stim_done <= 1;
                end else if (gap_left > 0) begin
                    i_valid <= 0; gap_left <= gap_left - 1;
                end else begin
                    i_valid <= 1;
                    i_data_byte <= byte_q.pop_front();
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Monitor: own stall pattern, compare with the oldest expected result
    always @(posedge i_clk) begin
        pes_pkg::t_result got, want;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_payload_byte, o_has_byte, o_first_of_packet, o_last_of_packet,
                        o_stream_number, o_stream_class, o_sub_stream, o_pts_value,
                        o_pts_present, o_dts_value, o_dts_present, o_payload_count};
                if (result_q.size() == 0) begin
                    errors++;
                    if (mismatches < 10) $display("unexpected result %p", got);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (mismatches < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        mismatches++;
                    end
                end
            end
            i_stall <= (cycles % 97) < 20 ? ($urandom_range(0, 1) == 1) : 1'b0;
        end
    end

    // Run end and timeout
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 200000) begin
                $display("Regression FAIL");
                $finish;
            end
            if (stim_done && result_q.size() == 0) begin
                repeat (20) @(posedge i_clk);
                if (errors == 0 && result_q.size() == 0)
                    $display("Regression PASS");
                else
                    $display("Regression FAIL");
                $finish;
            end
        end
    end
endmodule
